>>> design/hpbp_pkg.sv
// Package for the HPACK header block parser: event codes, representation kinds,
// parse phase encoding and the structs shared between the parser modules.
// No dependencies.
package hpbp_pkg;

  localparam int STATIC_ENTRIES_DEF  = 61;
  localparam int DYN_ENTRIES_MAX_DEF = 64;

  // First-byte pattern bits of a representation.
  localparam logic [7:0] BIT_INDEXED  = 8'h80;
  localparam logic [7:0] BIT_INCR     = 8'h40;
  localparam logic [7:0] BIT_SIZE_UPD = 8'h20;

  // Prefix masks of the representation integers.
  localparam logic [7:0] PFX_INDEXED  = 8'h7F;
  localparam logic [7:0] PFX_INCR     = 8'h3F;
  localparam logic [7:0] PFX_SIZE_UPD = 8'h1F;
  localparam logic [7:0] PFX_PLAIN    = 8'h0F;
  localparam logic [6:0] PFX_STRLEN   = 7'h7F;

  // Largest shift that still accepts a continuation byte.
  localparam logic [5:0] INT_SHIFT_MAX  = 6'd28;
  localparam logic [5:0] INT_SHIFT_STEP = 6'd7;

  localparam logic [1:0] REP_INDEXED  = 2'd0;
  localparam logic [1:0] REP_INCR     = 2'd1;
  localparam logic [1:0] REP_PLAIN    = 2'd2;
  localparam logic [1:0] REP_SIZE_UPD = 2'd3;

  localparam logic [2:0] EV_INDEXED   = 3'd0;
  localparam logic [2:0] EV_STR_START = 3'd4;
  localparam logic [2:0] EV_STR_BYTE  = 3'd5;
  localparam logic [2:0] EV_FRAME_END = 3'd6;
  localparam logic [2:0] EV_ERROR     = 3'd7;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
  localparam logic [1:0] ERR_TRUNCATED = 2'd3;

  localparam logic [1:0] BLK_NOT_END = 2'd0;
  localparam logic [1:0] BLK_MORE    = 2'd1;
  localparam logic [1:0] BLK_DONE    = 2'd2;

  typedef enum logic [5:0] {
    PH_REP          = 6'b000001,
    PH_REP_INT      = 6'b000010,
    PH_STRLEN       = 6'b000100,
    PH_STRLEN_PLAIN = 6'b001000,
    PH_STRLEN_HUFF  = 6'b010000,
    PH_STR          = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] int_accum;
    logic [5:0]  int_shift;
    logic [1:0]  rep_kind;
    logic [31:0] string_remaining;
    logic        cur_is_name;
    logic        draining;
  } parse_state_t;

  typedef struct packed {
    logic [31:0] accum;
    logic [5:0]  shift;
    logic        done;
    logic        overflow;
  } int_step_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] event_value;
    logic        index_is_dynamic;
    logic        string_huffman;
    logic        string_is_name;
    logic        string_byte_last;
    logic [1:0]  error_code;
    logic [1:0]  block_status;
  } event_t;

endpackage

>>> design/hpbp_if.sv
// Stream interfaces of the HPACK header block parser: payload bytes and events.
// Depends on nothing; each interface has a source and a sink modport.
interface hpbp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;
  logic       end_headers_flag;

  modport source (output valid, data_byte, frame_last, end_headers_flag, input ready);
  modport sink   (input valid, data_byte, frame_last, end_headers_flag, output ready);
endinterface

interface hpbp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [31:0] event_value;
  logic        index_is_dynamic;
  logic        string_huffman;
  logic        string_is_name;
  logic        string_byte_last;
  logic [1:0]  error_code;
  logic [1:0]  block_status;

  modport source (output valid, event_kind, event_value, index_is_dynamic, string_huffman,
                  string_is_name, string_byte_last, error_code, block_status,
                  input ready);
  modport sink   (input valid, event_kind, event_value, index_is_dynamic, string_huffman,
                  string_is_name, string_byte_last, error_code, block_status,
                  output ready);
endinterface

>>> design/hpbp_int_step.sv
// One continuation byte of an HPACK prefix integer, with overflow detection.
// Depends on hpbp_pkg.
module hpbp_int_step (
  input  logic [31:0]        accum,
  input  logic [5:0]         shift,
  input  logic [7:0]         data_byte,
  output hpbp_pkg::int_step_t step
);

  logic [39:0] addend;
  logic [39:0] sum;

  assign addend = 40'(data_byte[6:0]) << shift;
  assign sum    = {8'd0, accum} + addend;

  always_comb begin
    step.accum    = sum[31:0];
    step.shift    = shift + hpbp_pkg::INT_SHIFT_STEP;
    step.done     = ~data_byte[7];
    // More than five continuation bytes, or a value past 32 bits.
    step.overflow = (shift > hpbp_pkg::INT_SHIFT_MAX) || (sum[39:32] != 8'd0);
  end

endmodule

>>> design/hpbp_decode.sv
// Next-state and event logic of the HPACK parser for one registered byte.
// Depends on hpbp_pkg and hpbp_int_step.
module hpbp_decode #(
  parameter int STATIC_ENTRIES  = hpbp_pkg::STATIC_ENTRIES_DEF,
  parameter int DYN_ENTRIES_MAX = hpbp_pkg::DYN_ENTRIES_MAX_DEF,
  parameter int DYN_W           = $clog2(DYN_ENTRIES_MAX + 1)
) (
  input  hpbp_pkg::parse_state_t st,
  input  logic [DYN_W-1:0]       dyn_count,
  input  logic [7:0]             data_byte,
  input  logic                   frame_last,
  input  logic                   end_headers_flag,
  output hpbp_pkg::parse_state_t st_next,
  output logic [DYN_W-1:0]       dyn_count_next,
  output logic                   ev_valid,
  output hpbp_pkg::event_t       ev
);

  hpbp_pkg::int_step_t step;

  hpbp_int_step u_int_step (
    .accum     (st.int_accum),
    .shift     (st.int_shift),
    .data_byte (data_byte),
    .step      (step)
  );

  logic [31:0] dyn32;
  logic [32:0] dyn_limit;

  assign dyn32     = 32'(dyn_count);
  assign dyn_limit = 33'(STATIC_ENTRIES) + {1'b0, dyn32};

  always_comb begin
    logic        do_finish;
    logic        do_start;
    logic        do_done;
    logic [31:0] fin_v;
    logic [31:0] str_len;
    logic        str_huff;
    logic [1:0]  rk;
    logic [7:0]  mask;
    logic [7:0]  prefix;
    logic [31:0] rem;

    st_next        = st;
    dyn_count_next = dyn_count;
    ev_valid       = 1'b0;
    ev             = '0;
    do_finish      = 1'b0;
    do_start       = 1'b0;
    do_done        = 1'b0;
    fin_v          = step.accum;
    str_len        = step.accum;
    str_huff       = 1'b0;
    rk             = st.rep_kind;
    mask           = hpbp_pkg::PFX_PLAIN;
    prefix         = '0;
    rem            = st.string_remaining - 32'd1;

    if (st.draining) begin
      if (frame_last) begin
        ev_valid         = 1'b1;
        ev.event_kind    = hpbp_pkg::EV_FRAME_END;
        st_next.draining = 1'b0;
        st_next.phase    = hpbp_pkg::PH_REP;
      end
    end else begin
      unique case (st.phase) inside
        hpbp_pkg::PH_REP_INT: begin
          if (step.overflow) begin
            ev_valid      = 1'b1;
            ev.event_kind = hpbp_pkg::EV_ERROR;
            ev.error_code = hpbp_pkg::ERR_OVERFLOW;
          end else begin
            st_next.int_accum = step.accum;
            st_next.int_shift = step.shift;
            do_finish         = step.done;
          end
        end
        hpbp_pkg::PH_STRLEN: begin
          if (data_byte[6:0] != hpbp_pkg::PFX_STRLEN) begin
            do_start = 1'b1;
            str_len  = 32'(data_byte[6:0]);
            str_huff = data_byte[7];
          end else begin
            st_next.int_accum = 32'(hpbp_pkg::PFX_STRLEN);
            st_next.int_shift = '0;
            st_next.phase     = data_byte[7] ? hpbp_pkg::PH_STRLEN_HUFF
                                             : hpbp_pkg::PH_STRLEN_PLAIN;
          end
        end
        hpbp_pkg::PH_STRLEN_PLAIN, hpbp_pkg::PH_STRLEN_HUFF: begin
          if (step.overflow) begin
            ev_valid      = 1'b1;
            ev.event_kind = hpbp_pkg::EV_ERROR;
            ev.error_code = hpbp_pkg::ERR_OVERFLOW;
          end else begin
            st_next.int_accum = step.accum;
            st_next.int_shift = step.shift;
            do_start          = step.done;
            str_huff          = (st.phase == hpbp_pkg::PH_STRLEN_HUFF);
          end
        end
        hpbp_pkg::PH_STR: begin
          st_next.string_remaining = rem;
          ev_valid            = 1'b1;
          ev.event_kind       = hpbp_pkg::EV_STR_BYTE;
          ev.event_value      = 32'(data_byte);
          ev.string_is_name   = st.cur_is_name;
          ev.string_byte_last = (rem == 32'd0);
          do_done             = (rem == 32'd0);
        end
        default: begin
          // Start of a representation, sorted by its leading bits.
          if ((data_byte & hpbp_pkg::BIT_INDEXED) != 8'd0) begin
            rk   = hpbp_pkg::REP_INDEXED;
            mask = hpbp_pkg::PFX_INDEXED;
          end else if ((data_byte & hpbp_pkg::BIT_INCR) != 8'd0) begin
            rk   = hpbp_pkg::REP_INCR;
            mask = hpbp_pkg::PFX_INCR;
          end else if ((data_byte & hpbp_pkg::BIT_SIZE_UPD) != 8'd0) begin
            rk   = hpbp_pkg::REP_SIZE_UPD;
            mask = hpbp_pkg::PFX_SIZE_UPD;
          end else begin
            rk   = hpbp_pkg::REP_PLAIN;
            mask = hpbp_pkg::PFX_PLAIN;
          end
          prefix            = data_byte & mask;
          st_next.rep_kind  = rk;
          st_next.int_accum = 32'(prefix);
          st_next.int_shift = '0;
          fin_v             = 32'(prefix);
          if (prefix < mask) begin
            do_finish = 1'b1;
          end else begin
            st_next.phase = hpbp_pkg::PH_REP_INT;
          end
        end
      endcase

      if (do_finish) begin
        ev_valid = 1'b1;
        if (rk == hpbp_pkg::REP_SIZE_UPD) begin
          if (fin_v < dyn32) begin
            dyn_count_next = fin_v[DYN_W-1:0];
          end
          ev.event_kind  = {1'b0, rk};
          ev.event_value = fin_v;
          st_next.phase  = hpbp_pkg::PH_REP;
        end else if (rk != hpbp_pkg::REP_INDEXED && fin_v == 32'd0) begin
          // Literal with a new name: a name string comes first.
          ev.event_kind       = {1'b0, rk};
          st_next.cur_is_name = 1'b1;
          st_next.phase       = hpbp_pkg::PH_STRLEN;
        end else if (fin_v == 32'd0 || {1'b0, fin_v} > dyn_limit) begin
          ev.event_kind = hpbp_pkg::EV_ERROR;
          ev.error_code = hpbp_pkg::ERR_UNKNOWN;
        end else begin
          ev.event_kind       = {1'b0, rk};
          ev.event_value      = fin_v;
          ev.index_is_dynamic = (fin_v > 32'(STATIC_ENTRIES));
          if (rk == hpbp_pkg::REP_INDEXED) begin
            st_next.phase = hpbp_pkg::PH_REP;
          end else begin
            st_next.cur_is_name = 1'b0;
            st_next.phase       = hpbp_pkg::PH_STRLEN;
          end
        end
      end

      if (do_start) begin
        ev_valid          = 1'b1;
        ev.event_kind     = hpbp_pkg::EV_STR_START;
        ev.event_value    = str_len;
        ev.string_huffman = str_huff;
        ev.string_is_name = st.cur_is_name;
        if (str_len == 32'd0) begin
          do_done = 1'b1;
        end else begin
          st_next.string_remaining = str_len;
          st_next.phase            = hpbp_pkg::PH_STR;
        end
      end

      if (do_done) begin
        if (st.cur_is_name) begin
          st_next.cur_is_name = 1'b0;
          st_next.phase       = hpbp_pkg::PH_STRLEN;
        end else begin
          if (st.rep_kind == hpbp_pkg::REP_INCR &&
              dyn_count < DYN_W'(DYN_ENTRIES_MAX)) begin
            dyn_count_next = dyn_count + DYN_W'(1);
          end
          st_next.phase = hpbp_pkg::PH_REP;
        end
      end

      // A byte's own error takes precedence over truncation at frame end.
      if (ev_valid && ev.event_kind == hpbp_pkg::EV_ERROR) begin
        st_next.phase    = hpbp_pkg::PH_REP;
        st_next.draining = ~frame_last;
      end else if (frame_last && st_next.phase != hpbp_pkg::PH_REP) begin
        ev_valid      = 1'b1;
        ev            = '0;
        ev.event_kind = hpbp_pkg::EV_ERROR;
        ev.error_code = hpbp_pkg::ERR_TRUNCATED;
        st_next.phase = hpbp_pkg::PH_REP;
      end
    end

    if (frame_last && ev_valid) begin
      ev.block_status = end_headers_flag ? hpbp_pkg::BLK_DONE : hpbp_pkg::BLK_MORE;
    end else begin
      ev.block_status = hpbp_pkg::BLK_NOT_END;
    end
  end

endmodule

>>> design/hpbp_out_fifo.sv
// Two-entry event queue that decouples the parser from the event sink.
// Depends on hpbp_pkg and the hpbp_event_if interface.
module hpbp_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hpbp_pkg::event_t push_data,
  output logic             space,
  hpbp_event_if.source     events
);

  hpbp_pkg::event_t entry [2];
  logic [1:0]       count;
  logic             wr_ptr;
  logic             rd_ptr;
  logic             pop;
  hpbp_pkg::event_t head;

  assign space = (count != 2'd2);
  assign pop   = events.valid && events.ready;
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  assign events.valid            = (count != 2'd0);
  assign events.event_kind       = head.event_kind;
  assign events.event_value      = head.event_value;
  assign events.index_is_dynamic = head.index_is_dynamic;
  assign events.string_huffman   = head.string_huffman;
  assign events.string_is_name   = head.string_is_name;
  assign events.string_byte_last = head.string_byte_last;
  assign events.error_code       = head.error_code;
  assign events.block_status     = head.block_status;

endmodule

>>> design/hpack_header_block_parser_unit.sv
// Top level of the HPACK header block parser: input register, parse state and
// event queue. Depends on hpbp_pkg, hpbp_if, hpbp_decode and hpbp_out_fifo.
//
//   channel   modport   payload                                         moves
//   bytes     sink      data_byte, frame_last, end_headers_flag         one byte request
//   events    source    event_kind .. block_status                      zero or one event
//
// One byte is accepted per cycle while bytes.ready is high; its event goes from the input
// register into the event queue, and the parse state advances with it, in one pass.
// Synchronous reset empties the input register and the event queue and returns
// the parser to the start of a representation with an empty dynamic table.
// A stalled event sink fills the two-entry queue; then the input register holds
// and bytes.ready drops until an event is taken.
module hpack_header_block_parser_unit #(
  parameter int STATIC_ENTRIES  = hpbp_pkg::STATIC_ENTRIES_DEF,
  parameter int DYN_ENTRIES_MAX = hpbp_pkg::DYN_ENTRIES_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  hpbp_byte_if.sink    bytes,
  hpbp_event_if.source events
);

  localparam int DYN_W = $clog2(DYN_ENTRIES_MAX + 1);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_eh;
  logic       s1_go;
  logic       space;

  hpbp_pkg::parse_state_t st;
  hpbp_pkg::parse_state_t st_next;
  logic [DYN_W-1:0]       dyn_count;
  logic [DYN_W-1:0]       dyn_count_next;
  logic                   ev_valid;
  hpbp_pkg::event_t       ev;

  assign bytes.ready = ~s1_valid || space;
  assign s1_go       = s1_valid && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.valid && bytes.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      s1_byte <= bytes.data_byte;
      s1_last <= bytes.frame_last;
      s1_eh   <= bytes.end_headers_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase            <= hpbp_pkg::PH_REP;
      st.int_accum        <= '0;
      st.int_shift        <= '0;
      st.rep_kind         <= '0;
      st.string_remaining <= '0;
      st.cur_is_name      <= 1'b0;
      st.draining         <= 1'b0;
      dyn_count           <= '0;
    end else if (s1_go) begin
      st        <= st_next;
      dyn_count <= dyn_count_next;
    end
  end

  hpbp_decode #(
    .STATIC_ENTRIES  (STATIC_ENTRIES),
    .DYN_ENTRIES_MAX (DYN_ENTRIES_MAX),
    .DYN_W           (DYN_W)
  ) u_decode (
    .st               (st),
    .dyn_count        (dyn_count),
    .data_byte        (s1_byte),
    .frame_last       (s1_last),
    .end_headers_flag (s1_eh),
    .st_next          (st_next),
    .dyn_count_next   (dyn_count_next),
    .ev_valid         (ev_valid),
    .ev               (ev)
  );

  hpbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_go && ev_valid),
    .push_data (ev),
    .space     (space),
    .events    (events)
  );

endmodule

>>> sim/hpbp_checker.sv
// Checker for the HPACK header block parser: watches the byte and event channels,
// predicts the event of every accepted byte and compares it with what comes out.
// Depends on hpbp_pkg and hpbp_if.
module hpbp_checker #(
  parameter int STATIC_ENTRIES  = hpbp_pkg::STATIC_ENTRIES_DEF,
  parameter int DYN_ENTRIES_MAX = hpbp_pkg::DYN_ENTRIES_MAX_DEF
) (
  input  logic  clk,
  input  logic  rst,
  hpbp_byte_if  bytes,
  hpbp_event_if events,
  output int    mismatches,
  output int    outstanding
);

  localparam int unsigned INT_MORE     = 0;
  localparam int unsigned INT_DONE     = 1;
  localparam int unsigned INT_OVERFLOW = 2;

  localparam int unsigned IDX_UNKNOWN = 0;
  localparam int unsigned IDX_STATIC  = 1;
  localparam int unsigned IDX_DYNAMIC = 2;

  hpbp_pkg::phase_t phase;
  logic [31:0]      accum;
  logic [5:0]       shift;
  logic [1:0]       rep;
  logic [31:0]      str_left;
  logic             in_name;
  int               dyn_fill;
  logic             draining;

  logic             ev_hit;
  hpbp_pkg::event_t ev_next;
  hpbp_pkg::event_t expected_events[$];

  function automatic void raise_event(logic [2:0] kind, logic [31:0] value, logic dyn,
                                      logic huff, logic name, logic last, logic [1:0] err);
    ev_hit                   = 1'b1;
    ev_next.event_kind       = kind;
    ev_next.event_value      = value;
    ev_next.index_is_dynamic = dyn;
    ev_next.string_huffman   = huff;
    ev_next.string_is_name   = name;
    ev_next.string_byte_last = last;
    ev_next.error_code       = err;
    ev_next.block_status     = hpbp_pkg::BLK_NOT_END;
  endfunction

  // Adds one continuation byte of a prefix integer.
  function automatic int unsigned int_step(logic [7:0] b);
    logic [63:0] sum;
    if (shift > hpbp_pkg::INT_SHIFT_MAX) return INT_OVERFLOW;
    sum = {32'd0, accum} + ({57'd0, b[6:0]} << shift);
    if (sum[63:32] != 32'd0) return INT_OVERFLOW;
    accum = sum[31:0];
    shift = shift + hpbp_pkg::INT_SHIFT_STEP;
    return b[7] ? INT_MORE : INT_DONE;
  endfunction

  function automatic int unsigned classify_index(logic [31:0] idx);
    if (idx == 32'd0) return IDX_UNKNOWN;
    if (idx <= 32'(STATIC_ENTRIES)) return IDX_STATIC;
    if (idx - 32'(STATIC_ENTRIES) <= 32'(dyn_fill)) return IDX_DYNAMIC;
    return IDX_UNKNOWN;
  endfunction

  function automatic void string_done();
    if (in_name) begin
      in_name = 1'b0;
      phase   = hpbp_pkg::PH_STRLEN;
    end else begin
      // A completed incremental literal adds one entry to the dynamic table.
      if (rep == hpbp_pkg::REP_INCR && dyn_fill < DYN_ENTRIES_MAX) dyn_fill++;
      phase = hpbp_pkg::PH_REP;
    end
  endfunction

  function automatic void start_string(logic huff, logic [31:0] len);
    raise_event(hpbp_pkg::EV_STR_START, len, 1'b0, huff, in_name, 1'b0,
                hpbp_pkg::ERR_NONE);
    if (len == 32'd0) begin
      string_done();
    end else begin
      str_left = len;
      phase    = hpbp_pkg::PH_STR;
    end
  endfunction

  function automatic void finish_rep();
    int unsigned cls;
    if (rep == hpbp_pkg::REP_SIZE_UPD) begin
      if (accum < 32'(dyn_fill)) dyn_fill = int'(accum);
      raise_event({1'b0, hpbp_pkg::REP_SIZE_UPD}, accum, 1'b0, 1'b0, 1'b0, 1'b0,
                  hpbp_pkg::ERR_NONE);
      phase = hpbp_pkg::PH_REP;
      return;
    end
    // A literal with name index zero carries its name as a string.
    if (rep != hpbp_pkg::REP_INDEXED && accum == 32'd0) begin
      raise_event({1'b0, rep}, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, hpbp_pkg::ERR_NONE);
      in_name = 1'b1;
      phase   = hpbp_pkg::PH_STRLEN;
      return;
    end
    cls = classify_index(accum);
    if (cls == IDX_UNKNOWN) begin
      raise_event(hpbp_pkg::EV_ERROR, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                  hpbp_pkg::ERR_UNKNOWN);
      return;
    end
    raise_event({1'b0, rep}, accum, cls == IDX_DYNAMIC, 1'b0, 1'b0, 1'b0,
                hpbp_pkg::ERR_NONE);
    if (rep == hpbp_pkg::REP_INDEXED) begin
      phase = hpbp_pkg::PH_REP;
    end else begin
      in_name = 1'b0;
      phase   = hpbp_pkg::PH_STRLEN;
    end
  endfunction

  function automatic void start_int(logic [7:0] b, logic [7:0] mask);
    accum = {24'd0, b & mask};
    shift = '0;
    if (accum < {24'd0, mask}) finish_rep();
    else phase = hpbp_pkg::PH_REP_INT;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic fl, logic eh);
    int unsigned st;
    logic        huff;
    ev_hit  = 1'b0;
    ev_next = '0;
    if (draining) begin
      if (fl) begin
        raise_event(hpbp_pkg::EV_FRAME_END, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                    hpbp_pkg::ERR_NONE);
        draining = 1'b0;
        phase    = hpbp_pkg::PH_REP;
      end
    end else begin
      case (phase) inside
        hpbp_pkg::PH_REP_INT: begin
          st = int_step(b);
          if (st == INT_OVERFLOW) begin
            raise_event(hpbp_pkg::EV_ERROR, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                        hpbp_pkg::ERR_OVERFLOW);
          end else if (st == INT_DONE) begin
            finish_rep();
          end
        end
        hpbp_pkg::PH_STRLEN: begin
          if (b[6:0] < hpbp_pkg::PFX_STRLEN) begin
            start_string(b[7], {25'd0, b[6:0]});
          end else begin
            accum = {25'd0, hpbp_pkg::PFX_STRLEN};
            shift = '0;
            phase = b[7] ? hpbp_pkg::PH_STRLEN_HUFF : hpbp_pkg::PH_STRLEN_PLAIN;
          end
        end
        hpbp_pkg::PH_STRLEN_PLAIN, hpbp_pkg::PH_STRLEN_HUFF: begin
          huff = (phase == hpbp_pkg::PH_STRLEN_HUFF);
          st   = int_step(b);
          if (st == INT_OVERFLOW) begin
            raise_event(hpbp_pkg::EV_ERROR, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                        hpbp_pkg::ERR_OVERFLOW);
          end else if (st == INT_DONE) begin
            start_string(huff, accum);
          end
        end
        hpbp_pkg::PH_STR: begin
          str_left = str_left - 32'd1;
          raise_event(hpbp_pkg::EV_STR_BYTE, {24'd0, b}, 1'b0, 1'b0, in_name,
                      str_left == 32'd0, hpbp_pkg::ERR_NONE);
          if (str_left == 32'd0) string_done();
        end
        default: begin
          if ((b & hpbp_pkg::BIT_INDEXED) != 8'd0) begin
            rep = hpbp_pkg::REP_INDEXED;
            start_int(b, hpbp_pkg::PFX_INDEXED);
          end else if ((b & hpbp_pkg::BIT_INCR) != 8'd0) begin
            rep = hpbp_pkg::REP_INCR;
            start_int(b, hpbp_pkg::PFX_INCR);
          end else if ((b & hpbp_pkg::BIT_SIZE_UPD) != 8'd0) begin
            rep = hpbp_pkg::REP_SIZE_UPD;
            start_int(b, hpbp_pkg::PFX_SIZE_UPD);
          end else begin
            rep = hpbp_pkg::REP_PLAIN;
            start_int(b, hpbp_pkg::PFX_PLAIN);
          end
        end
      endcase
      // An error drains the frame; a frame that ends mid-representation is truncated.
      if (ev_hit && ev_next.event_kind == hpbp_pkg::EV_ERROR) begin
        phase    = hpbp_pkg::PH_REP;
        draining = !fl;
      end else if (fl && phase != hpbp_pkg::PH_REP) begin
        raise_event(hpbp_pkg::EV_ERROR, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                    hpbp_pkg::ERR_TRUNCATED);
        phase = hpbp_pkg::PH_REP;
      end
    end
    if (fl && ev_hit) ev_next.block_status = eh ? hpbp_pkg::BLK_DONE : hpbp_pkg::BLK_MORE;
  endfunction

  function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_event();
    hpbp_pkg::event_t want;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event, expected none, got kind %0d value %0h", $time,
               events.event_kind, events.event_value);
      mismatches++;
      return;
    end
    want = expected_events.pop_front();
    check_field("event_kind", 32'(want.event_kind), 32'(events.event_kind));
    check_field("event_value", want.event_value, events.event_value);
    check_field("index_is_dynamic", 32'(want.index_is_dynamic),
                32'(events.index_is_dynamic));
    check_field("string_huffman", 32'(want.string_huffman), 32'(events.string_huffman));
    check_field("string_is_name", 32'(want.string_is_name), 32'(events.string_is_name));
    check_field("string_byte_last", 32'(want.string_byte_last),
                32'(events.string_byte_last));
    check_field("error_code", 32'(want.error_code), 32'(events.error_code));
    check_field("block_status", 32'(want.block_status), 32'(events.block_status));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      phase      = hpbp_pkg::PH_REP;
      accum      = '0;
      shift      = '0;
      rep        = hpbp_pkg::REP_INDEXED;
      str_left   = '0;
      in_name    = 1'b0;
      dyn_fill   = 0;
      draining   = 1'b0;
      mismatches = 0;
      expected_events.delete();
    end else begin
      if (events.valid && events.ready) compare_event();
      if (bytes.valid && bytes.ready) begin
        decode_byte(bytes.data_byte, bytes.frame_last, bytes.end_headers_flag);
        if (ev_hit) expected_events.insert(expected_events.size(), ev_next);
      end
    end
    outstanding <= expected_events.size();
  end

endmodule

>>> sim/tb_top.sv
// Top of the HPACK header block parser testbench: clock, reset, byte stimulus,
// event sink stalls and the verdict. Depends on hpbp_pkg, hpbp_if, the parser
// top level and hpbp_checker.
module tb_top;

  localparam int STALL_PCT      = 12;
  localparam int RANDOM_ITEMS   = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int STEADY_FROM    = 400;
  localparam int STEADY_TO      = 650;

  localparam logic [7:0] BIT_NEVER_IDX = 8'h10;
  localparam logic [7:0] BIT_HUFF      = 8'h80;
  localparam logic [7:0] INT_CONT_ALL  = 8'hFF;

  logic clk;
  logic rst;
  logic steady;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  int   idle_cycles;
  int   table_guess;
  logic [7:0] frame_bytes[$];

  hpbp_byte_if  bytes();
  hpbp_event_if events();

  hpack_header_block_parser_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .bytes  (bytes),
    .events (events)
  );

  hpbp_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .bytes       (bytes),
    .events      (events),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) events.ready <= 1'b0;
    else events.ready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (rst || (bytes.valid && bytes.ready) || (events.valid && events.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic fl, logic eh);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      bytes.valid <= 1'b0;
      @(posedge clk);
    end
    bytes.valid            <= 1'b1;
    bytes.data_byte        <= b;
    bytes.frame_last       <= fl;
    bytes.end_headers_flag <= eh;
    @(posedge clk);
    while (!bytes.ready) @(posedge clk);
    items_sent++;
    steady = (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
  endtask

  task automatic send_frame(logic eh);
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1, eh);
  endtask

  // Holds the byte request low until every predicted event has come out.
  task automatic wait_drained();
    bytes.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic void put_byte(logic [7:0] b);
    frame_bytes.insert(frame_bytes.size(), b);
  endfunction

  function automatic void put_int(logic [7:0] pattern, logic [7:0] mask, logic [31:0] value);
    logic [31:0] rest;
    if (value < {24'd0, mask}) begin
      put_byte(pattern | value[7:0]);
      return;
    end
    put_byte(pattern | mask);
    rest = value - {24'd0, mask};
    while (rest >= 32'd128) begin
      put_byte({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    put_byte({1'b0, rest[6:0]});
  endfunction

  function automatic void put_string();
    int r;
    int len;
    r = int'($urandom_range(99));
    if (r < 70) len = int'($urandom_range(5));
    else if (r < 97) len = int'($urandom_range(6, 20));
    else len = int'($urandom_range(120, 140));
    put_int($urandom_range(1) ? BIT_HUFF : 8'h00, {1'b0, hpbp_pkg::PFX_STRLEN}, 32'(len));
    repeat (len) put_byte(8'($urandom_range(255)));
  endfunction

  function automatic logic [31:0] pick_index();
    int r;
    r = int'($urandom_range(99));
    if (r < 75) return 32'($urandom_range(1, hpbp_pkg::STATIC_ENTRIES_DEF + table_guess));
    if (r < 88) begin
      return 32'(hpbp_pkg::STATIC_ENTRIES_DEF + table_guess) + 32'($urandom_range(1, 3));
    end
    if (r < 94) return 32'd0;
    return $urandom();
  endfunction

  // A prefix integer whose continuation bytes run past 32 bits.
  function automatic void put_overflow(logic [7:0] pattern, logic [7:0] mask);
    put_byte(pattern | mask);
    repeat (5) put_byte(INT_CONT_ALL);
    put_byte(8'h01);
  endfunction

  function automatic void put_rep();
    int          r;
    logic        incr;
    logic [31:0] idx;
    logic [31:0] size;
    r = int'($urandom_range(99));
    if (r < 35) begin
      put_int(hpbp_pkg::BIT_INDEXED, hpbp_pkg::PFX_INDEXED, pick_index());
    end else if (r < 80) begin
      incr = (r < 58);
      idx  = ($urandom_range(99) < 40) ? 32'd0 : pick_index();
      if (incr) put_int(hpbp_pkg::BIT_INCR, hpbp_pkg::PFX_INCR, idx);
      else put_int($urandom_range(1) ? BIT_NEVER_IDX : 8'h00, hpbp_pkg::PFX_PLAIN, idx);
      if (idx == 32'd0) put_string();
      put_string();
      if (incr && table_guess < hpbp_pkg::DYN_ENTRIES_MAX_DEF) table_guess++;
    end else if (r < 92) begin
      r = int'($urandom_range(99));
      if (r < 50) size = 32'($urandom_range(0, table_guess + 2));
      else if (r < 80) size = 32'($urandom_range(200));
      else size = $urandom();
      put_int(hpbp_pkg::BIT_SIZE_UPD, hpbp_pkg::PFX_SIZE_UPD, size);
      if (size < 32'(table_guess)) table_guess = int'(size);
    end else if (r < 96) begin
      put_overflow(hpbp_pkg::BIT_INDEXED, hpbp_pkg::PFX_INDEXED);
    end else begin
      put_int(hpbp_pkg::BIT_INCR, hpbp_pkg::PFX_INCR,
              32'($urandom_range(1, hpbp_pkg::STATIC_ENTRIES_DEF)));
      put_overflow(8'h00, {1'b0, hpbp_pkg::PFX_STRLEN});
    end
  endfunction

  task automatic send_random_frame();
    int r;
    int n;
    r = int'($urandom_range(99));
    frame_bytes.delete();
    if (r < 7) begin
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(255)));
    end else if (r < 11) begin
      // Many small incremental literals to push the table toward saturation.
      n = int'($urandom_range(8, 20));
      repeat (n) begin
        put_int(hpbp_pkg::BIT_INCR, hpbp_pkg::PFX_INCR, 32'd1);
        put_byte(8'h00);
        if (table_guess < hpbp_pkg::DYN_ENTRIES_MAX_DEF) table_guess++;
      end
    end else begin
      repeat ($urandom_range(1, 4)) put_rep();
      if (r >= 85 && frame_bytes.size() > 1) begin
        n = int'($urandom_range(1, frame_bytes.size() - 1));
        frame_bytes = frame_bytes[0:n-1];
      end
    end
    send_frame($urandom_range(1));
  endtask

  initial begin
    rst                     = 1'b1;
    steady                  = 1'b0;
    items_sent              = 0;
    table_guess             = 0;
    bytes.valid             = 1'b0;
    bytes.data_byte         = 8'd0;
    bytes.frame_last        = 1'b0;
    bytes.end_headers_flag  = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Indices 1 and 61, a new-name literal that fills dynamic entry 62, a plain
    // literal with a continued name index, size updates to 0 and 4096.
    frame_bytes = {8'h81, 8'hBD, 8'h40, 8'h81, 8'h00, 8'h01, 8'hFF, 8'hBE,
                   8'h0F, 8'h00, 8'h00, 8'h20, 8'h3F, 8'hE1, 8'h1F};
    send_frame(1'b1);
    // Index zero mid-frame, then the drained frame end.
    frame_bytes = {8'h80, 8'h81};
    send_frame(1'b0);
    // Integer overflow on the last byte of the frame.
    frame_bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(1'b1);
    // Frame ends inside a value string.
    frame_bytes = {8'h41, 8'h05, 8'h11};
    send_frame(1'b1);
    // Dynamic index on an empty table, as the last byte.
    frame_bytes = {8'hBE};
    send_frame(1'b0);
    wait_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      send_random_frame();
      if ($urandom_range(99) < 3) wait_drained();
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
